/* src/slfs_pkg.sv */
// Shared types and constants for the serpentine LED frame sender.
`timescale 1ns / 1ps
package slfs_pkg;

	typedef enum logic {
		OP_DRAW = 1'b0,
		OP_SEND = 1'b1
	} op_t;

	// configuration register indexes
	localparam logic [2:0] REG_WIDTH         = 3'd0;
	localparam logic [2:0] REG_HEIGHT        = 3'd1;
	localparam logic [2:0] REG_FIRST_START   = 3'd2;
	localparam logic [2:0] REG_FIRST_LENGTH  = 3'd3;
	localparam logic [2:0] REG_SECOND_START  = 3'd4;
	localparam logic [2:0] REG_SECOND_LENGTH = 3'd5;
	localparam logic [2:0] REG_THIRD_START   = 3'd6;
	localparam logic [2:0] REG_THIRD_LENGTH  = 3'd7;

	localparam logic [31:0] WORD_START = 32'h0000_0000;
	localparam logic [31:0] WORD_END   = 32'hFFFF_FFFF;
	localparam logic [7:0]  PIX_MARK   = 8'hFF;
	localparam logic [11:0] END_ROUND  = 12'd63;
	localparam int          END_SHIFT  = 6;

	typedef struct packed {
		logic [10:0] width;
		logic [10:0] height;
	} geom_t;

	typedef struct packed {
		logic [2:0][9:0]  start;
		logic [2:0][10:0] len;
	} strips_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t         op;
		logic        on_sign;
		logic [21:0] row_base;
		logic [10:0] col;
		logic [23:0] bgr;
	} qent_t;

endpackage

/* src/slfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module slfs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/slfs_front.sv */
// Front end: takes items, range-checks draws and forms the row base and column.
`timescale 1ns / 1ps
module slfs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic signed [15:0]    pos_x,
	input  logic signed [15:0]    pos_y,
	input  logic [31:0]           color,
	input  slfs_pkg::geom_t       geom,
	input  logic                  busy,
	output logic                  q_valid,
	input  logic                  q_ready,
	output slfs_pkg::qent_t       q_data
);

	import slfs_pkg::*;

	logic   valid_s1;
	qent_t  ent_s1;
	qent_t  ent_d;
	logic   take;
	logic   x_ok;
	logic   y_ok;
	logic [10:0] ux;
	logic [10:0] uy;

	assign in_ready = !busy && (!valid_s1 || q_ready);
	assign take     = in_valid && in_ready;

	always_comb begin
		x_ok = !pos_x[15] && ({1'b0, pos_x[14:0]} < {5'd0, geom.width});
		y_ok = !pos_y[15] && ({1'b0, pos_y[14:0]} < {5'd0, geom.height});
		ux   = pos_x[10:0];
		uy   = pos_y[10:0];
		ent_d.op       = op_t'(operation);
		ent_d.on_sign  = x_ok && y_ok;
		ent_d.row_base = 22'(uy) * 22'(geom.width);
		// even rows run right to left
		ent_d.col      = uy[0] ? ux : (geom.width - 11'd1 - ux);
		ent_d.bgr      = {color[7:0], color[15:8], color[23:16]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_s1 <= ent_d;
		end
	end

	assign q_valid = valid_s1;
	assign q_data  = ent_s1;

endmodule

/* src/slfs_queue.sv */
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module slfs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  slfs_pkg::qent_t  push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output slfs_pkg::qent_t  pop_data
);

	import slfs_pkg::*;

	qent_t       mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

/* src/slfs_back.sv */
// Back end: pixel store with clearing pass, draw writes and the frame sequencer.
`timescale 1ns / 1ps
module slfs_back #(
	parameter int MAX_LEDS    = 1024,
	parameter int STRIP_COUNT = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  slfs_pkg::strips_t  strips,
	input  logic               q_valid,
	output logic               q_ready,
	input  slfs_pkg::qent_t    q_data,
	output logic               busy,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        word,
	output logic [1:0]         strip,
	output logic               frame_last
);

	import slfs_pkg::*;

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int IW = (AW + 1 > 12) ? AW + 1 : 12;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_START,
		PH_PIXELS,
		PH_END
	} phase_t;

	typedef enum logic [1:0] {
		K_ZERO,
		K_PIX,
		K_ONES
	} kind_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  strip;
		logic [10:0] pc;
		logic [5:0]  ec;
	} seq_t;

	localparam logic [2:0] NO_STRIP = 3'd3;

	// first strip at or after from with nonzero length, NO_STRIP if none
	function automatic logic [2:0] next_active(logic [2:0] from, strips_t c);
		logic [2:0] r;
		r = NO_STRIP;
		for (int i = 2; i >= 0; i--) begin
			if (3'(i) >= from && i < STRIP_COUNT && c.len[i] != 11'd0) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	function automatic seq_t begin_strip(logic [2:0] s);
		seq_t r;
		r.phase = (s == NO_STRIP) ? PH_IDLE : PH_START;
		r.strip = (s == NO_STRIP) ? 2'd0 : s[1:0];
		r.pc    = '0;
		r.ec    = '0;
		return r;
	endfunction

	// skip stages that have nothing left under the current lengths
	function automatic seq_t settle(seq_t q, strips_t c);
		seq_t        r;
		logic [10:0] len;
		logic [5:0]  ends;
		r    = q;
		len  = c.len[q.strip];
		ends = 6'((12'(len) + END_ROUND) >> END_SHIFT);
		if (r.phase == PH_PIXELS && r.pc >= len) begin
			r.phase = PH_END;
			r.ec    = '0;
		end
		if (r.phase == PH_END && r.ec >= ends) begin
			r = begin_strip(next_active(3'(q.strip) + 3'd1, c));
		end
		return r;
	endfunction

	seq_t            seq_q;
	logic            busy_q;
	logic [AW-1:0]   clr_q;

	logic            valid_s1;
	kind_t           kind_s1;
	logic            oob_s1;
	logic [1:0]      strip_s1;
	logic            last_s1;

	logic            out_valid_q;
	logic [31:0]     word_q;
	logic [1:0]      strip_q;
	logic            last_q;

	seq_t            pre;
	seq_t            nxt;
	seq_t            post;
	logic            emit;
	logic            out_free;
	logic            s1_free;
	logic            pop;
	logic            is_send;
	logic            send_go;
	logic [IW-1:0]   rd_full;
	logic            rd_oob;
	logic            rd_en;
	logic [22:0]     draw_idx;
	logic            draw_we;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [23:0]     ram_wdata;
	logic [23:0]     ram_rdata;
	kind_t           kind_d;

	assign out_free = !out_valid_q || out_ready;
	assign s1_free  = !valid_s1 || out_free;
	assign is_send  = (q_data.op == OP_SEND);
	assign q_ready  = !busy_q && (!is_send || s1_free);
	assign pop      = q_valid && q_ready;
	assign send_go  = pop && is_send;

	always_comb begin
		pre  = (seq_q.phase == PH_IDLE) ? begin_strip(next_active(3'd0, strips)) : seq_q;
		pre  = settle(pre, strips);
		emit = (pre.phase != PH_IDLE);
		nxt  = pre;
		case (pre.phase)
			PH_START: begin
				nxt.phase = PH_PIXELS;
				nxt.pc    = '0;
				kind_d    = K_ZERO;
			end
			PH_PIXELS: begin
				nxt.pc = pre.pc + 11'd1;
				kind_d = K_PIX;
			end
			PH_END: begin
				nxt.ec = pre.ec + 6'd1;
				kind_d = K_ONES;
			end
			default: begin
				kind_d = K_ZERO;
			end
		endcase
		post    = settle(nxt, strips);
		rd_full = IW'(strips.start[pre.strip]) + IW'(pre.pc);
		rd_oob  = (rd_full >= IW'(MAX_LEDS));
		rd_en   = send_go && emit && (pre.phase == PH_PIXELS) && !rd_oob;
	end

	always_comb begin
		draw_idx  = 23'(q_data.row_base) + 23'(q_data.col);
		draw_we   = pop && !is_send && q_data.on_sign && (draw_idx < 23'(MAX_LEDS));
		ram_we    = busy_q || draw_we;
		ram_waddr = busy_q ? clr_q : draw_idx[AW-1:0];
		ram_wdata = busy_q ? 24'd0 : q_data.bgr;
	end

	slfs_ram #(
		.WIDTH(24),
		.DEPTH(MAX_LEDS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(rd_full[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= '{phase: PH_IDLE, strip: 2'd0, pc: '0, ec: '0};
			busy_q      <= 1'b1;
			clr_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (busy_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(MAX_LEDS - 1)) begin
					busy_q <= 1'b0;
				end
			end

			if (send_go) begin
				seq_q <= emit ? post : pre;
			end

			if (send_go && emit) begin
				valid_s1 <= 1'b1;
				kind_s1  <= kind_d;
				oob_s1   <= rd_oob;
				strip_s1 <= pre.strip;
				last_s1  <= (post.phase == PH_IDLE);
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end

			if (valid_s1 && out_free) begin
				out_valid_q <= 1'b1;
				strip_q     <= strip_s1;
				last_q      <= last_s1;
				case (kind_s1)
					K_PIX:   word_q <= {PIX_MARK, oob_s1 ? 24'd0 : ram_rdata};
					K_ONES:  word_q <= WORD_END;
					default: word_q <= WORD_START;
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign busy       = busy_q;
	assign out_valid  = out_valid_q;
	assign word       = word_q;
	assign strip      = strip_q;
	assign frame_last = last_q;

	// no item leaves the queue while the store is being cleared
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !pop)
		else $error("queue popped during clearing pass");

	// every store read lands in stage one as a pixel word
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (valid_s1 && kind_s1 == K_PIX))
		else $error("store read without a pixel word in stage one");

	// the sequencer never points past the last strip
	a_strip_range: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q.strip != 2'd3)
		else $error("strip index out of range");

	// a finished frame leaves the sequencer idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(send_go && emit && post.phase == PH_IDLE) |=> (seq_q.phase == PH_IDLE))
		else $error("sequencer not idle after last word");

endmodule

/* src/serpentine_led_frame_sender_top.sv */
// Top level: configuration registers, front end, queue and back end.
`timescale 1ns / 1ps
// A send item passes the front register, the queue, stage one and the output register before its word appears.
// Throughput: one item per cycle, draw or send, while the output is taken and no clearing pass runs.
// A draw passes the front register and the queue before it writes the pixel store; no result.
// Reset: after arst_n releases, a clearing pass zeroes every entry of the store
// with in_ready low; config writes are taken throughout.
module serpentine_led_frame_sender_top #(
	parameter int MAX_LEDS    = 1024,
	parameter int STRIP_COUNT = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [31:0]        color,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        word,
	output logic [1:0]         strip,
	output logic               frame_last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [10:0]        cfg_data
);

	import slfs_pkg::*;

	geom_t    geom_q;
	strips_t  strips_q;
	logic     busy;
	logic     fq_valid;
	logic     fq_ready;
	qent_t    fq_data;
	logic     bq_valid;
	logic     bq_ready;
	qent_t    bq_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q   <= '{width: 11'd1, height: 11'd1};
			strips_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:         geom_q.width     <= cfg_data;
				REG_HEIGHT:        geom_q.height    <= cfg_data;
				REG_FIRST_START:   strips_q.start[0] <= cfg_data[9:0];
				REG_FIRST_LENGTH:  strips_q.len[0]   <= cfg_data;
				REG_SECOND_START:  strips_q.start[1] <= cfg_data[9:0];
				REG_SECOND_LENGTH: strips_q.len[1]   <= cfg_data;
				REG_THIRD_START:   strips_q.start[2] <= cfg_data[9:0];
				REG_THIRD_LENGTH:  strips_q.len[2]   <= cfg_data;
				default:           geom_q            <= geom_q;
			endcase
		end
	end

	slfs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.color    (color),
		.geom     (geom_q),
		.busy     (busy),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_data   (fq_data)
	);

	slfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data (fq_data),
		.pop_valid (bq_valid),
		.pop_ready (bq_ready),
		.pop_data  (bq_data)
	);

	slfs_back #(
		.MAX_LEDS   (MAX_LEDS),
		.STRIP_COUNT(STRIP_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.strips    (strips_q),
		.q_valid   (bq_valid),
		.q_ready   (bq_ready),
		.q_data    (bq_data),
		.busy      (busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.word      (word),
		.strip     (strip),
		.frame_last(frame_last)
	);

endmodule
